// File: src/mbps_pkg.sv
`default_nettype none
package mbps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int MASK_W      = 32;
  localparam int NUM_WORDS   = 4;

  localparam logic [LEN_W-1:0]  LEN_MASK   = 6'h3F;
  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0040_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN0  = 3'd0,
    REG_PATTERN1  = 3'd1,
    REG_PATTERN2  = 3'd2,
    REG_PATTERN3  = 3'd3,
    REG_WILDCARD  = 3'd4,
    REG_LENGTH    = 3'd5,
    REG_SCAN_BASE = 3'd6
  } reg_index_t;

  // Byte k sits in bits 8k+7..8k, same packing as the pattern words.
  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_vec_t;
  typedef logic [NUM_WORDS-1:0][CFG_DATA_W-1:0] pattern_words_t;

endpackage
`default_nettype wire

// File: src/mbps_if.sv
`default_nettype none
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_region;

  modport source(output valid, output data_byte, output end_of_region, input ready);
  modport sink(input valid, input data_byte, input end_of_region, output ready);
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_address;

  modport source(output valid, output found, output match_address, input ready);
  modport sink(input valid, input found, input match_address, output ready);
endinterface
`default_nettype wire

// File: src/masked_byte_pattern_scan_unit.sv
`default_nettype none
// Latency: a result is shown in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle unless the result stalls; all window positions are
// compared in parallel in one pass between the input handshake and result register.
// Reset: synchronous, active high; clears the window, counters and result valid,
// and loads the registers with their reset values (scan base 0x00400000).
module masked_byte_pattern_scan_unit
  import mbps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  mbps_in_if.sink                    scan_in,
  mbps_out_if.source                 result
);

  pattern_words_t    pattern_words;
  logic [MASK_W-1:0] wildcard_mask;
  logic [LEN_W-1:0]  pattern_length;
  logic [ADDR_W-1:0] scan_base;

  byte_vec_t         window;
  byte_vec_t         window_next;
  logic [ADDR_W-1:0] byte_count;
  logic [ADDR_W-1:0] byte_count_next;
  logic [FILL_W-1:0] window_fill;
  logic [FILL_W-1:0] window_fill_next;
  logic              match_reported;

  logic              out_valid;
  logic              out_found;
  logic [ADDR_W-1:0] out_address;

  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] span;
  logic [ADDR_W-1:0] hit_address;
  logic              window_hit;
  logic              hit;
  logic              produce;
  logic              accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      wildcard_mask  <= '0;
      pattern_length <= '0;
      scan_base      <= BASE_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PATTERN0:  pattern_words[0] <= cfg_data;
        REG_PATTERN1:  pattern_words[1] <= cfg_data;
        REG_PATTERN2:  pattern_words[2] <= cfg_data;
        REG_PATTERN3:  pattern_words[3] <= cfg_data;
        REG_WILDCARD:  wildcard_mask    <= cfg_data[MASK_W-1:0];
        REG_LENGTH:    pattern_length   <= cfg_data[LEN_W-1:0] & LEN_MASK;
        REG_SCAN_BASE: scan_base        <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept        = scan_in.valid && scan_in.ready;
  assign scan_in.ready = !out_valid || result.ready;

  assign window_next      = {window[MAX_PATTERN-2:0], scan_in.data_byte};
  assign byte_count_next  = byte_count + ADDR_W'(1);
  assign window_fill_next = (window_fill < FILL_W'(MAX_PATTERN))
                            ? window_fill + FILL_W'(1) : window_fill;

  assign len  = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                        : pattern_length;
  assign span = (len == '0) ? ADDR_W'(1) : ADDR_W'(len);

  mbps_matcher u_matcher (
    .window        (window_next),
    .pattern       (byte_vec_t'(pattern_words)),
    .wildcard_mask (wildcard_mask),
    .len           (len),
    .hit           (window_hit)
  );

  // A match counts only once all of its bytes have arrived in this region.
  assign hit = !match_reported && (LEN_W'(window_fill_next) >= len) && window_hit;
  assign hit_address = scan_base + byte_count_next - span;
  assign produce = hit || (scan_in.end_of_region && !match_reported);

  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      byte_count     <= '0;
      window_fill    <= '0;
      match_reported <= 1'b0;
    end else if (accept) begin
      if (scan_in.end_of_region) begin
        window         <= '0;
        byte_count     <= '0;
        window_fill    <= '0;
        match_reported <= 1'b0;
      end else begin
        window         <= window_next;
        byte_count     <= byte_count_next;
        window_fill    <= window_fill_next;
        match_reported <= match_reported || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && produce) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      out_found   <= hit;
      out_address <= hit ? hit_address : '0;
    end
  end

  assign result.valid         = out_valid;
  assign result.found         = out_found;
  assign result.match_address = out_address;

`ifndef NO_ASSERTIONS
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |-> result.match_address == '0)
    else $error("not-found word carries a nonzero address");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    accept && scan_in.end_of_region |=>
      byte_count == '0 && window_fill == '0 && !match_reported)
    else $error("scan state not cleared after end of region");

  a_reported_count: assert property (@(posedge clk) disable iff (rst)
    match_reported |-> byte_count != '0 && window_fill != '0)
    else $error("match flagged in an empty region");
`endif

endmodule
`default_nettype wire

// File: src/mbps_matcher.sv
`default_nettype none
module mbps_matcher
  import mbps_pkg::*;
(
  input  wire byte_vec_t          window,
  input  wire byte_vec_t          pattern,
  input  wire logic [MASK_W-1:0]  wildcard_mask,
  input  wire logic [LEN_W-1:0]   len,
  output logic                    hit
);

  logic [MAX_PATTERN-1:0] pos_ok;

  // Window position a (age a, newest is 0) lines up with pattern byte len-1-a.
  for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_pos
    logic [IDX_W-1:0] pidx;
    assign pidx = IDX_W'(len - LEN_W'(a) - LEN_W'(1));
    assign pos_ok[a] = (LEN_W'(a) >= len) || wildcard_mask[pidx]
                       || (window[a] == pattern[pidx]);
  end

  assign hit = &pos_ok;

endmodule
`default_nettype wire

// File: verif/masked_byte_pattern_scan_unit_test.sv
`timescale 1ns / 100ps
module masked_byte_pattern_scan_unit_test;
  import mbps_pkg::*;

  // Index past the end of the register list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } scan_word_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mbps_in_if scan_in();
  mbps_out_if result();

  masked_byte_pattern_scan_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .scan_in(scan_in),
    .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies as last written.
  pattern_words_t pattern = '0;
  logic [MASK_W-1:0] wild_mask = '0;
  logic [LEN_W-1:0] pat_len = '0;
  logic [ADDR_W-1:0] scan_base = BASE_RESET;

  // Scanner state tracked alongside the block.
  byte_vec_t window = '0;
  int unsigned fill = 0;
  logic [ADDR_W-1:0] count = '0;
  bit reported = 1'b0;

  scan_word_t bytes_to_send[$];
  scan_report_t expected_reports[$];
  int unsigned mismatch_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned src_gap_pct = 0;
  int unsigned sink_stall_pct = 0;

  function automatic logic [BYTE_W-1:0] pat_byte_at(int unsigned k);
    logic [NUM_WORDS*CFG_DATA_W-1:0] flat;
    flat = pattern;
    return flat[8*k +: 8];
  endfunction

  function automatic int unsigned active_len();
    return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
  endfunction

  function automatic void track_scan_byte(logic [BYTE_W-1:0] data, logic last);
    bit was_reported;
    bit hit;
    bit produced;
    int unsigned len;
    int unsigned span;
    scan_report_t rep;
    was_reported = reported;
    produced = 1'b0;
    window = {window[MAX_PATTERN-2:0], data};
    if (fill < MAX_PATTERN) fill++;
    count++;
    len = active_len();
    hit = !was_reported && fill >= len;
    for (int j = 0; j < len; j++) begin
      if (!wild_mask[j] && window[len-1-j] != pat_byte_at(j)) hit = 1'b0;
    end
    if (hit) begin
      span = (len == 0) ? 1 : len;
      rep.found = 1'b1;
      rep.addr = scan_base + count - ADDR_W'(span);
      expected_reports.push_back(rep);
      reported = 1'b1;
      produced = 1'b1;
    end
    if (last) begin
      if (!produced && !was_reported) begin
        rep.found = 1'b0;
        rep.addr = '0;
        expected_reports.push_back(rep);
      end
      window = '0;
      count = '0;
      fill = 0;
      reported = 1'b0;
    end
  endfunction

  function automatic void log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // Driver: a new word is presented once the previous one has been taken.
  always @(posedge clk) begin
    scan_word_t w;
    if (rst) begin
      scan_in.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (scan_in.valid && scan_in.ready)
        track_scan_byte(scan_in.data_byte, scan_in.end_of_region);
      if (!scan_in.valid || scan_in.ready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          scan_in.valid <= 1'b0;
        end else if (bytes_to_send.size() != 0 && $urandom_range(99) < src_gap_pct) begin
          src_gap <= $urandom_range(1, 12) - 1;
          scan_in.valid <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          w = bytes_to_send.pop_front();
          scan_in.valid <= 1'b1;
          scan_in.data_byte <= w.data;
          scan_in.end_of_region <= w.last;
        end else begin
          scan_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result-side stalls.
  always @(posedge clk) begin
    scan_report_t want;
    if (rst) begin
      result.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_reports.size() == 0) begin
          log_mismatch($sformatf("unexpected result: found=%0b address=%08h",
                                 result.found, result.match_address));
        end else begin
          want = expected_reports.pop_front();
          if (result.found !== want.found || result.match_address !== want.addr)
            log_mismatch($sformatf("expected found=%0b address=%08h, got found=%0b address=%08h",
                                   want.found, want.addr, result.found, result.match_address));
        end
      end
      if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        result.ready <= 1'b0;
      end else if ($urandom_range(99) < sink_stall_pct) begin
        sink_gap <= $urandom_range(1, 12) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  function automatic void push_word(logic [BYTE_W-1:0] data, logic last);
    scan_word_t w;
    w.data = data;
    w.last = last;
    bytes_to_send.push_back(w);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PATTERN0, REG_PATTERN1, REG_PATTERN2, REG_PATTERN3: pattern[idx[1:0]] = val;
      REG_WILDCARD: wild_mask = val[MASK_W-1:0];
      REG_LENGTH: pat_len = val[LEN_W-1:0] & LEN_MASK;
      REG_SCAN_BASE: scan_base = val[ADDR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued word is taken and every result has come back.
  // A word that produces no result may still be in the pipeline, hence the tail.
  task automatic wait_quiet();
    do @(posedge clk);
    while (bytes_to_send.size() != 0 || scan_in.valid || expected_reports.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_config(int phase);
    logic [CFG_DATA_W-1:0] val;
    int unsigned len;
    write_reg(REG_PATTERN0, pick_word());
    write_reg(REG_PATTERN1, pick_word());
    write_reg(REG_PATTERN2, pick_word());
    write_reg(REG_PATTERN3, pick_word());
    val = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: val[MASK_W-1:0] = '0;
      1: val[MASK_W-1:0] = '1;
      2: val[MASK_W-1:0] = $urandom & $urandom & $urandom;
      default: ;
    endcase
    write_reg(REG_WILDCARD, val);
    case (phase)
      1: len = MAX_PATTERN;
      2: len = $urandom_range(MAX_PATTERN + 1, 63);
      3: len = 0;
      default:
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = 1;
          2: len = MAX_PATTERN;
          3: len = $urandom_range(MAX_PATTERN + 1, 63);
          4, 5: len = $urandom_range(9, MAX_PATTERN - 1);
          default: len = $urandom_range(2, 8);
        endcase
    endcase
    val = {$urandom, $urandom};
    val[LEN_W-1:0] = LEN_W'(len);
    write_reg(REG_LENGTH, val);
    val = {$urandom, $urandom};
    case (phase)
      2: val[ADDR_W-1:0] = '0;
      3: val[ADDR_W-1:0] = '1;
      default:
        case ($urandom_range(0, 4))
          0: val[ADDR_W-1:0] = '0;
          1: val[ADDR_W-1:0] = '1;
          2: val[ADDR_W-1:0] = 32'hFFFF_FFF0 + $urandom_range(0, 15);
          default: ;
        endcase
    endcase
    write_reg(REG_SCAN_BASE, val);
    if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, {$urandom, $urandom});
  endtask

  // Queues one region, usually with the pattern planted somewhere in it.
  // Some plants get one fixed byte corrupted, and a few regions are left open.
  function automatic int unsigned queue_region();
    logic [BYTE_W-1:0] region_bytes[$];
    int unsigned len;
    int unsigned n;
    int unsigned start_pos;
    int unsigned j;
    bit close;
    len = active_len();
    case ($urandom_range(0, 9))
      0: n = $urandom_range(1, 4);
      1: n = $urandom_range(40, 80);
      2: n = (len > 1) ? len - 1 : 1;
      default: n = len + $urandom_range(0, 12);
    endcase
    if (n == 0) n = 1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) region_bytes.push_back(pat_byte_at($urandom_range(0, 31)));
      else region_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) != 0 && len > 0 && len <= n) begin
      start_pos = $urandom_range(0, n - len);
      for (int k = 0; k < len; k++) begin
        if (!wild_mask[k]) region_bytes[start_pos + k] = pat_byte_at(k);
      end
      if ($urandom_range(0, 3) == 0) begin
        j = $urandom_range(0, len - 1);
        if (!wild_mask[j]) region_bytes[start_pos + j] ^= 8'h01 << $urandom_range(0, 7);
      end
    end
    close = $urandom_range(0, 9) != 0;
    for (int i = 0; i < n; i++) push_word(region_bytes[i], close && i == n - 1);
    return n;
  endfunction

  initial begin
    int unsigned queued;
    scan_in.valid = 1'b0;
    scan_in.data_byte = '0;
    scan_in.end_of_region = 1'b0;
    result.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: an empty pattern matches on the first byte of each region.
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h5A, 1'b1);
    push_word(8'hA5, 1'b1);
    wait_quiet();

    // Three-byte pattern with a wildcard in the middle; the base wraps.
    write_reg(REG_NONE, '1);
    write_reg(REG_PATTERN0, 64'h0000_0000_0034_0012);
    write_reg(REG_WILDCARD, 64'h2);
    write_reg(REG_LENGTH, 64'd3);
    write_reg(REG_SCAN_BASE, 64'hFFFF_FFFE);
    push_word(8'h12, 1'b0);
    push_word(8'h34, 1'b0);
    push_word(8'h12, 1'b0);
    push_word(8'h99, 1'b0);
    push_word(8'h34, 1'b0);
    push_word(8'h55, 1'b0);
    push_word(8'h12, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h34, 1'b0);
    push_word(8'hFF, 1'b1);
    // Match completing on the last byte, then a region with no match.
    push_word(8'h12, 1'b0);
    push_word(8'h77, 1'b0);
    push_word(8'h34, 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b1);
    wait_quiet();

    // An all-zero pattern must not match the cleared window before it fills.
    write_reg(REG_PATTERN0, 64'h0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b1);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b1);
    wait_quiet();

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 2))
        0: src_gap_pct = 0;
        1: src_gap_pct = 10;
        default: src_gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: sink_stall_pct = 0;
        1: sink_stall_pct = 10;
        default: sink_stall_pct = 30;
      endcase
      if (p == 9) begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
      end
      random_config(p);
      queued = 0;
      while (queued < 175) queued += queue_region();
      wait_quiet();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
src/mbps_pkg.sv
src/mbps_if.sv
src/mbps_matcher.sv
src/masked_byte_pattern_scan_unit.sv
verif/masked_byte_pattern_scan_unit_test.sv
